>>> hdl/hpts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpts_pkg: shared types and constants for the heater plate plant step
// Reset values, command codes, register indexes and a saturation helper.
// ----------------------------------------------------------------------------
package hpts_pkg;

  localparam int unsigned CfgW = 31;
  localparam int unsigned IdxW = 3;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SET_CURRENT = 2'd1;
  localparam logic [1:0] CMD_LOAD_CHANGE = 2'd2;

  localparam logic [IdxW-1:0] REG_AMBIENT = 3'd0;
  localparam logic [IdxW-1:0] REG_LOAD_AMB_G = 3'd1;
  localparam logic [IdxW-1:0] REG_PLATE_AMB_G = 3'd2;
  localparam logic [IdxW-1:0] REG_PLATE_LOAD_G = 3'd3;
  localparam logic [IdxW-1:0] REG_SUPPLY_V = 3'd4;
  localparam logic [IdxW-1:0] REG_SLEW = 3'd5;
  localparam logic [IdxW-1:0] REG_MAX_I = 3'd6;
  localparam logic [IdxW-1:0] REG_PLATE_C = 3'd7;

  localparam logic [CfgW-1:0] RST_AMBIENT = 31'd19529728;
  localparam logic [CfgW-1:0] RST_LOAD_AMB_G = 31'd4915200;
  localparam logic [CfgW-1:0] RST_PLATE_AMB_G = 31'd983040;
  localparam logic [CfgW-1:0] RST_PLATE_LOAD_G = 31'd3276800;
  localparam logic [CfgW-1:0] RST_SUPPLY_V = 31'd7864320;
  localparam logic [CfgW-1:0] RST_SLEW = 31'd524288;
  localparam logic [CfgW-1:0] RST_MAX_I = 31'd3276800;
  localparam logic [CfgW-1:0] RST_PLATE_C = 31'd22607381;
  localparam logic signed [31:0] RST_LOAD_T = 32'sd18546688;
  localparam logic [CfgW-1:0] RST_LOAD_C = 31'd273940480;

  typedef struct packed {
    logic       start;
    logic       is_mul;
    logic signed [63:0] a;
    logic signed [32:0] b;
  } hpts_op_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

>>> hdl/hpts_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpts_alu: shared multi-cycle arithmetic unit
// Signed multiply (a*b >>> 16, toward zero) over 33 shift-add steps, or
// signed divide (a*65536 / b, toward zero) over 80 restoring steps.
// ----------------------------------------------------------------------------
module hpts_alu (
  input  logic                    clk,
  input  logic                    rst,
  input  hpts_pkg::hpts_op_t      op,
  output logic                    done,
  output logic signed [63:0]      res
);
  import hpts_pkg::*;

  logic        busy, mode, neg;
  logic [6:0]  cnt;
  logic [79:0] acc;
  logic [63:0] mag_a;
  logic [32:0] mag_b;
  logic [80:0] rem;
  logic [63:0] quo;
  logic [80:0] rem_sh;
  logic [80:0] dsub;

  assign rem_sh = {rem[79:0], mag_a[63]};
  assign dsub = rem_sh - {48'd0, mag_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !op.start && (cnt == 7'd0);
      if (op.start) begin
        busy <= 1'b1;
        mode <= op.is_mul;
        neg <= op.a[63] ^ op.b[32];
        mag_a <= op.a[63] ? 64'(-op.a) : 64'(op.a);
        mag_b <= op.b[32] ? 33'(-op.b) : 33'(op.b);
        acc <= '0;
        rem <= '0;
        quo <= '0;
        cnt <= op.is_mul ? 7'd33 : 7'd80;
      end else if (busy) begin
        if (cnt == 7'd0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 7'd1;
          if (mode) begin
            if (mag_b[0]) acc <= acc + {16'd0, mag_a};
            mag_a <= {mag_a[62:0], 1'b0};
            mag_b <= {1'b0, mag_b[32:1]};
          end else begin
            mag_a <= {mag_a[62:0], 1'b0};
            if (!dsub[80]) begin
              rem <= dsub;
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[62:0], 1'b0};
            end
          end
        end
      end
    end
  end

  logic [63:0] mag_r;
  always_comb begin
    mag_r = mode ? acc[79:16] : quo;
    res = neg ? -$signed(mag_r) : $signed(mag_r);
  end

endmodule

>>> hdl/heater_plate_thermal_plant_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_plate_thermal_plant_step_top: heated plate plant emulator
// Input channel in_valid/in_stall carries a command; output channel
// out_valid/out_stall returns the state after it.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfer on the input channel is taken when in_valid is high
//   and in_stall low. Every command produces exactly one output transfer
//   holding load_temp, plate_temp and heater_current.
//   A tick runs 13 operations on one shared multiply/divide unit, and
//   out_valid rises once the last of them has finished. Set current uses
//   one multiply; a load change or an unused command goes straight to the
//   output state. in_stall is high from the transfer until the result
//   has been taken, so no new command is taken before then.
//   The result sits in an output register; while out_stall is high it holds
//   and no new command is taken.
//   Synchronous reset loads the default registers and plant state and clears
//   out_valid. Configuration writes (cfg_we, cfg_index, cfg_data) are
//   taken in any cycle but belong only in idle periods.
// ----------------------------------------------------------------------------
module heater_plate_thermal_plant_step_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    cmd,
  input  logic [30:0]                   time_step,
  input  logic signed [31:0]            requested_current,
  input  logic [30:0]                   new_load_heat_capacity,
  input  logic [30:0]                   new_load_temp,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            load_temp,
  output logic signed [31:0]            plate_temp,
  output logic [30:0]                   heater_current,
  input  logic                          cfg_we,
  input  logic [hpts_pkg::IdxW-1:0]     cfg_index,
  input  logic [hpts_pkg::CfgW-1:0]     cfg_data
);
  import hpts_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_OUT = 3'd3;

  logic [CfgW-1:0] amb, g_la, g_pa, g_pl, volt, slew, imax, cp;
  logic signed [31:0] lt, pt;
  logic [30:0] cur, lc;
  logic [2:0] state;
  logic [3:0] step;
  logic [30:0] dt;
  logic signed [31:0] req;
  logic signed [31:0] tmp;
  hpts_op_t op;
  logic done;
  logic signed [63:0] res;
  logic signed [31:0] r32;

  hpts_alu u_alu (.clk(clk), .rst(rst), .op(op), .done(done), .res(res));

  assign r32 = sat32(66'(res));
  assign in_stall = (state != S_IDLE);

  function automatic logic [32:0] capv(input logic [30:0] c);
    return (c == 31'd0) ? 33'd1 : {2'b00, c};
  endfunction

  always_comb begin
    op.start = (state == S_ISSUE);
    op.is_mul = 1'b1;
    op.a = '0;
    op.b = '0;
    unique case (step)
      4'd0: begin op.a = 64'($signed({1'b0, amb})) - 64'(lt); op.b = {2'b0, g_la}; end
      4'd1: begin op.a = 64'(tmp); op.b = {2'b0, dt}; end
      4'd2: begin op.is_mul = 1'b0; op.a = 64'(tmp); op.b = capv(lc); end
      4'd3: begin op.a = 64'($signed({1'b0, cur})); op.b = {2'b0, dt}; end
      4'd4: begin op.a = 64'(tmp); op.b = {2'b0, volt}; end
      4'd5: begin op.is_mul = 1'b0; op.a = 64'(tmp); op.b = capv(cp); end
      4'd6: begin op.a = 64'($signed({1'b0, amb})) - 64'(pt); op.b = {2'b0, g_pa}; end
      4'd7: begin op.a = 64'(tmp); op.b = {2'b0, dt}; end
      4'd8: begin op.is_mul = 1'b0; op.a = 64'(tmp); op.b = capv(cp); end
      4'd9: begin op.a = 64'(pt) - 64'(lt); op.b = {2'b0, g_pl}; end
      4'd10: begin op.a = 64'(tmp); op.b = {2'b0, dt}; end
      4'd11: begin op.is_mul = 1'b0; op.a = 64'(tmp); op.b = capv(lc); end
      4'd12: begin op.is_mul = 1'b0; op.a = 64'(tmp); op.b = capv(cp); end
      4'd13: begin op.a = 64'({33'd0, slew}); op.b = {2'b0, dt}; end
      default: begin op.a = '0; op.b = '0; end
    endcase
  end

  logic signed [32:0] tgt, diff, mag;
  always_comb begin
    if (req > $signed({1'b0, imax})) tgt = 33'($signed({1'b0, imax}));
    else if (req < 0) tgt = '0;
    else tgt = 33'(req);
    diff = tgt - $signed({2'b0, cur});
    mag = diff[32] ? -diff : diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amb <= RST_AMBIENT; g_la <= RST_LOAD_AMB_G; g_pa <= RST_PLATE_AMB_G;
      g_pl <= RST_PLATE_LOAD_G; volt <= RST_SUPPLY_V; slew <= RST_SLEW;
      imax <= RST_MAX_I; cp <= RST_PLATE_C;
      lt <= RST_LOAD_T; pt <= $signed({1'b0, RST_AMBIENT});
      cur <= '0; lc <= RST_LOAD_C;
      state <= S_IDLE; out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_AMBIENT: amb <= cfg_data;
          REG_LOAD_AMB_G: g_la <= cfg_data;
          REG_PLATE_AMB_G: g_pa <= cfg_data;
          REG_PLATE_LOAD_G: g_pl <= cfg_data;
          REG_SUPPLY_V: volt <= cfg_data;
          REG_SLEW: slew <= cfg_data;
          REG_MAX_I: imax <= cfg_data;
          REG_PLATE_C: cp <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            dt <= time_step; req <= requested_current;
            if (cmd == CMD_TICK) begin
              step <= 4'd0; state <= S_ISSUE;
            end else if (cmd == CMD_SET_CURRENT) begin
              step <= 4'd13; state <= S_ISSUE;
            end else begin
              if (cmd == CMD_LOAD_CHANGE) begin
                lc <= new_load_heat_capacity;
                lt <= $signed({1'b0, new_load_temp});
              end
              state <= S_OUT;
            end
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (done) begin
            state <= (step == 4'd12 || step == 4'd13) ? S_OUT : S_ISSUE;
            step <= step + 4'd1;
            // plate-load energy is kept for the plate update
            if (step != 4'd11) tmp <= r32;
            unique case (step)
              4'd2, 4'd11: lt <= sat32(66'(lt) + 66'(r32));
              4'd5, 4'd8: pt <= sat32(66'(pt) + 66'(r32));
              4'd12: pt <= sat32(66'(pt) - 66'(r32));
              4'd13: begin
                if (66'(mag) <= 66'(res)) cur <= tgt[30:0];
                else if (!diff[32]) cur <= 31'(66'(cur) + 66'(res));
                else cur <= 31'(66'(cur) - 66'(res));
              end
              default: ;
            endcase
          end
        end
        S_OUT: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign load_temp = lt;
  assign plate_temp = pt;
  assign heater_current = cur;

endmodule

>>> hdl/hpts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpts_checker: port-level checks for the plant step block
// Input closed while a result is pending and after a transfer; result held under out_stall.
// ----------------------------------------------------------------------------
module hpts_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [30:0] heater_current
);
  import hpts_pkg::*;

  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_cur_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(heater_current)) else $error("current moved");
  a_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("no busy after transfer");

endmodule

bind heater_plate_thermal_plant_step_top hpts_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .heater_current(heater_current)
);
